// ----- src/ccc_pkg.sv -----
package ccc_pkg;

    // Field widths of one item and one result.
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int CD_HR_W  = 7;

    localparam int TDATA_W  = 64;
    localparam int TUSER_W  = 4;

    // Calendar and countdown limits.
    localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_MAX   = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_MIN   = 4'd1;
    localparam logic [DAY_W-1:0]   DAY_MIN     = 5'd1;
    localparam logic [HOUR_W-1:0]  HOUR_MAX    = 5'd23;
    localparam logic [MIN_W-1:0]   MIN_MAX     = 6'd59;
    localparam logic [SEC_W-1:0]   SEC_MAX     = 6'd59;
    localparam logic [CD_HR_W-1:0] CD_HR_MAX   = 7'd99;
    localparam logic [YEAR_W-1:0]  YEAR_RESET  = 14'd2000;

    // Month numbers and lengths.
    localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR   = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN   = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP   = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV   = 4'd11;
    localparam logic [DAY_W-1:0]   DAYS_SHORT  = 5'd30;
    localparam logic [DAY_W-1:0]   DAYS_LONG   = 5'd31;
    localparam logic [DAY_W-1:0]   DAYS_FEB    = 5'd28;
    localparam logic [DAY_W-1:0]   DAYS_FEB_LP = 5'd29;

    // Divisibility by 25 over 14 bits: multiply by the inverse of 25 modulo 2^14;
    // the low bits of the product stay at or below 16383/25 only for multiples of 25.
    localparam logic [YEAR_W-1:0]  INV25       = 14'd7209;
    localparam logic [YEAR_W-1:0]  DIV25_LIMIT = 14'd655;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_LOAD_CAL = 2'd1,
        OP_LOAD_CD  = 2'd2,
        OP_STOP_CD  = 2'd3
    } ccc_op_t;

    // Sideband of an input item, lowest bit last.
    typedef struct packed {
        logic    countdown_selected;
        logic    pause_calendar;
        ccc_op_t opcode;
    } ccc_user_t;

    // Load fields of an input item, load_year in the lowest bits.
    typedef struct packed {
        logic [SEC_W-1:0]   load_cd_seconds;
        logic [MIN_W-1:0]   load_cd_minutes;
        logic [CD_HR_W-1:0] load_cd_hours;
        logic [SEC_W-1:0]   load_second;
        logic [MIN_W-1:0]   load_minute;
        logic [HOUR_W-1:0]  load_hour;
        logic [DAY_W-1:0]   load_day;
        logic [MONTH_W-1:0] load_month;
        logic [YEAR_W-1:0]  load_year;
    } ccc_load_t;

    // One result item, year in the lowest bits.
    typedef struct packed {
        logic               cd_done;
        logic               cd_running;
        logic [SEC_W-1:0]   cd_seconds;
        logic [MIN_W-1:0]   cd_minutes;
        logic [CD_HR_W-1:0] cd_hours;
        logic [SEC_W-1:0]   second;
        logic [MIN_W-1:0]   minute;
        logic [HOUR_W-1:0]  hour;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } ccc_result_t;

    localparam int LOAD_W   = $bits(ccc_load_t);
    localparam int RESULT_W = $bits(ccc_result_t);

    // Gregorian leap year test without a divider.
    function automatic logic ccc_is_leap(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] prod;
        logic              div25;
        begin
            prod  = YEAR_W'(y * INV25);
            div25 = (prod <= DIV25_LIMIT);
            return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
        end
    endfunction

    function automatic logic [DAY_W-1:0] ccc_month_len(input logic [MONTH_W-1:0] m,
                                                       input logic               leap);
        logic [DAY_W-1:0] len;
        begin
            if (m == MONTH_FEB)
            begin
                len = leap ? DAYS_FEB_LP : DAYS_FEB;
            end
            else if ((m == MONTH_APR) || (m == MONTH_JUN) ||
                     (m == MONTH_SEP) || (m == MONTH_NOV))
            begin
                len = DAYS_SHORT;
            end
            else
            begin
                len = DAYS_LONG;
            end
            return len;
        end
    endfunction

endpackage

// ----- src/calendar_clock_with_countdown_top.sv -----
// Channel  | Direction | Signals                     | Contents
// ---------+-----------+-----------------------------+------------------------------------
// s        | in        | s_tvalid s_tready s_tdata   | one operation with its load values
//          |           | s_tuser                     | opcode, pause and countdown flags
// m        | out       | m_tvalid m_tready m_tdata   | calendar and countdown after the op
//
// Every accepted item gives exactly one result item: the item is captured in an input
// register, the calendar and countdown update is one pass of compare and increment
// logic (plus one 14 by 14 bit product for the leap year test), and the result lands
// in the output register. One item per cycle is sustained while the output register's
// ready is high; that ready is the only thing that stalls the input.
// Reset (rst_n low, asynchronous) sets the calendar to 2000-01-01 00:00:00, clears
// the countdown and empties both stages.
module calendar_clock_with_countdown_top
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    // From bit 0: load_year[13:0], load_month[17:14], load_day[22:18],
    // load_hour[27:23], load_minute[33:28], load_second[39:34],
    // load_cd_hours[46:40], load_cd_minutes[52:47], load_cd_seconds[58:53],
    // zeros above.
    input  logic [ccc_pkg::TDATA_W-1:0]  s_tdata,
    // From bit 0: opcode[1:0], pause_calendar[2], countdown_selected[3].
    input  logic [ccc_pkg::TUSER_W-1:0]  s_tuser,

    output logic                          m_tvalid,
    input  logic                          m_tready,
    // From bit 0: year[13:0], month[17:14], day[22:18], hour[27:23],
    // minute[33:28], second[39:34], cd_hours[46:40], cd_minutes[52:47],
    // cd_seconds[58:53], cd_running[59], cd_done[60], zeros above.
    output logic [ccc_pkg::TDATA_W-1:0]  m_tdata
);

    // Input stage.
    logic                  in_valid_reg;
    ccc_pkg::ccc_user_t    in_user_reg;
    ccc_pkg::ccc_load_t    in_load_reg;

    // Output stage.
    logic                  out_valid_reg;
    ccc_pkg::ccc_result_t  out_data_reg;
    ccc_pkg::ccc_result_t  out_data_next;

    // Calendar and countdown state.
    logic [ccc_pkg::YEAR_W-1:0]  year_reg,       year_next;
    logic [ccc_pkg::MONTH_W-1:0] month_reg,      month_next;
    logic [ccc_pkg::DAY_W-1:0]   day_reg,        day_next;
    logic [ccc_pkg::HOUR_W-1:0]  hour_reg,       hour_next;
    logic [ccc_pkg::MIN_W-1:0]   minute_reg,     minute_next;
    logic [ccc_pkg::SEC_W-1:0]   second_reg,     second_next;
    logic [ccc_pkg::CD_HR_W-1:0] cd_hours_reg,   cd_hours_next;
    logic [ccc_pkg::MIN_W-1:0]   cd_minutes_reg, cd_minutes_next;
    logic [ccc_pkg::SEC_W-1:0]   cd_seconds_reg, cd_seconds_next;
    logic                        cd_running_reg, cd_running_next;
    logic                        cd_done;

    logic                        leap;
    logic [ccc_pkg::DAY_W-1:0]   month_days;
    logic                        advance;

    // The held item moves on whenever the output register is empty or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign leap       = ccc_pkg::ccc_is_leap(year_reg);
    assign month_days = ccc_pkg::ccc_month_len(month_reg, leap);

    // Next state for the held item.
    always_comb
    begin
        year_next       = year_reg;
        month_next      = month_reg;
        day_next        = day_reg;
        hour_next       = hour_reg;
        minute_next     = minute_reg;
        second_next     = second_reg;
        cd_hours_next   = cd_hours_reg;
        cd_minutes_next = cd_minutes_reg;
        cd_seconds_next = cd_seconds_reg;
        cd_running_next = cd_running_reg;
        cd_done         = 1'b0;

        unique case (in_user_reg.opcode)
            ccc_pkg::OP_TICK:
            begin
                // Carry ripples from seconds up to the year.
                if (!in_user_reg.pause_calendar)
                begin
                    if (second_reg < ccc_pkg::SEC_MAX)
                    begin
                        second_next = second_reg + 1'b1;
                    end
                    else
                    begin
                        second_next = '0;
                        if (minute_reg < ccc_pkg::MIN_MAX)
                        begin
                            minute_next = minute_reg + 1'b1;
                        end
                        else
                        begin
                            minute_next = '0;
                            if (hour_reg < ccc_pkg::HOUR_MAX)
                            begin
                                hour_next = hour_reg + 1'b1;
                            end
                            else
                            begin
                                hour_next = '0;
                                // A loaded day past the month's end also wraps here.
                                if (day_reg < month_days)
                                begin
                                    day_next = day_reg + 1'b1;
                                end
                                else
                                begin
                                    day_next = ccc_pkg::DAY_MIN;
                                    if (month_reg < ccc_pkg::MONTH_MAX)
                                    begin
                                        month_next = month_reg + 1'b1;
                                    end
                                    else
                                    begin
                                        month_next = ccc_pkg::MONTH_MIN;
                                        year_next  = (year_reg >= ccc_pkg::YEAR_MAX) ?
                                                     '0 : year_reg + 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end

                // Countdown with borrow; reaching it at zero stops it and flags done.
                if (cd_running_reg && in_user_reg.countdown_selected)
                begin
                    if ((cd_hours_reg == '0) && (cd_minutes_reg == '0) &&
                        (cd_seconds_reg == '0))
                    begin
                        cd_running_next = 1'b0;
                        cd_done         = 1'b1;
                    end
                    else if (cd_seconds_reg != '0)
                    begin
                        cd_seconds_next = cd_seconds_reg - 1'b1;
                    end
                    else
                    begin
                        cd_seconds_next = ccc_pkg::SEC_MAX;
                        if (cd_minutes_reg != '0)
                        begin
                            cd_minutes_next = cd_minutes_reg - 1'b1;
                        end
                        else
                        begin
                            cd_minutes_next = ccc_pkg::MIN_MAX;
                            cd_hours_next   = cd_hours_reg - 1'b1;
                        end
                    end
                end
            end

            ccc_pkg::OP_LOAD_CAL:
            begin
                // Each load value is clamped into its legal range; the day only to 1 through 31.
                year_next   = (in_load_reg.load_year > ccc_pkg::YEAR_MAX) ?
                              ccc_pkg::YEAR_MAX : in_load_reg.load_year;
                if (in_load_reg.load_month < ccc_pkg::MONTH_MIN)
                begin
                    month_next = ccc_pkg::MONTH_MIN;
                end
                else if (in_load_reg.load_month > ccc_pkg::MONTH_MAX)
                begin
                    month_next = ccc_pkg::MONTH_MAX;
                end
                else
                begin
                    month_next = in_load_reg.load_month;
                end
                day_next    = (in_load_reg.load_day < ccc_pkg::DAY_MIN) ?
                              ccc_pkg::DAY_MIN : in_load_reg.load_day;
                hour_next   = (in_load_reg.load_hour > ccc_pkg::HOUR_MAX) ?
                              ccc_pkg::HOUR_MAX : in_load_reg.load_hour;
                minute_next = (in_load_reg.load_minute > ccc_pkg::MIN_MAX) ?
                              ccc_pkg::MIN_MAX : in_load_reg.load_minute;
                second_next = (in_load_reg.load_second > ccc_pkg::SEC_MAX) ?
                              ccc_pkg::SEC_MAX : in_load_reg.load_second;
            end

            ccc_pkg::OP_LOAD_CD:
            begin
                cd_hours_next   = (in_load_reg.load_cd_hours > ccc_pkg::CD_HR_MAX) ?
                                  ccc_pkg::CD_HR_MAX : in_load_reg.load_cd_hours;
                cd_minutes_next = (in_load_reg.load_cd_minutes > ccc_pkg::MIN_MAX) ?
                                  ccc_pkg::MIN_MAX : in_load_reg.load_cd_minutes;
                cd_seconds_next = (in_load_reg.load_cd_seconds > ccc_pkg::SEC_MAX) ?
                                  ccc_pkg::SEC_MAX : in_load_reg.load_cd_seconds;
                cd_running_next = 1'b1;
            end

            ccc_pkg::OP_STOP_CD:
            begin
                cd_running_next = 1'b0;
            end
        endcase
    end

    // The result is the state after the operation.
    always_comb
    begin
        out_data_next.year       = year_next;
        out_data_next.month      = month_next;
        out_data_next.day        = day_next;
        out_data_next.hour       = hour_next;
        out_data_next.minute     = minute_next;
        out_data_next.second     = second_next;
        out_data_next.cd_hours   = cd_hours_next;
        out_data_next.cd_minutes = cd_minutes_next;
        out_data_next.cd_seconds = cd_seconds_next;
        out_data_next.cd_running = cd_running_next;
        out_data_next.cd_done    = cd_done;
    end

    // Handshake flags, calendar and countdown state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            year_reg       <= ccc_pkg::YEAR_RESET;
            month_reg      <= ccc_pkg::MONTH_MIN;
            day_reg        <= ccc_pkg::DAY_MIN;
            hour_reg       <= '0;
            minute_reg     <= '0;
            second_reg     <= '0;
            cd_hours_reg   <= '0;
            cd_minutes_reg <= '0;
            cd_seconds_reg <= '0;
            cd_running_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                year_reg       <= year_next;
                month_reg      <= month_next;
                day_reg        <= day_next;
                hour_reg       <= hour_next;
                minute_reg     <= minute_next;
                second_reg     <= second_next;
                cd_hours_reg   <= cd_hours_next;
                cd_minutes_reg <= cd_minutes_next;
                cd_seconds_reg <= cd_seconds_next;
                cd_running_reg <= cd_running_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_user_reg <= ccc_pkg::ccc_user_t'(s_tuser);
            in_load_reg <= ccc_pkg::ccc_load_t'(s_tdata[ccc_pkg::LOAD_W-1:0]);
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(ccc_pkg::TDATA_W - ccc_pkg::RESULT_W){1'b0}}, out_data_reg};

endmodule

// ----- tb/sv/tb.sv -----
module tb;

    // Cycles without any accepted item, on either side, before the run is declared hung.
    // The longest legal quiet stretch is the receiver's long hold, well below this.
    localparam int STALL_LIMIT  = 2000;
    // Length of the long receiver hold that fills the block and stalls its input.
    localparam int HOLD_CYCLES  = 300;
    // Rough number of items to send; the random part stops once it is reached.
    localparam int ITEM_COUNT   = 1550;
    // The last items of the run are sent and taken with no idling on either side.
    localparam int TAIL_ITEMS   = 200;
    // The block has two register stages; a few more cycles catch any stray result.
    localparam int DRAIN_CYCLES = 8;

    // Tracks the calendar and countdown as the block should hold them, and keeps
    // the state expected after each accepted item until its result comes back.
    class calendar_tracker;
        logic [ccc_pkg::YEAR_W-1:0]  year;
        logic [ccc_pkg::MONTH_W-1:0] month;
        logic [ccc_pkg::DAY_W-1:0]   day;
        logic [ccc_pkg::HOUR_W-1:0]  hour;
        logic [ccc_pkg::MIN_W-1:0]   minute;
        logic [ccc_pkg::SEC_W-1:0]   second;
        logic [ccc_pkg::CD_HR_W-1:0] cd_hours;
        logic [ccc_pkg::MIN_W-1:0]   cd_minutes;
        logic [ccc_pkg::SEC_W-1:0]   cd_seconds;
        logic                        cd_running;
        ccc_pkg::ccc_result_t        expected_states[$];
        int                          errors;
        int                          results_seen;

        function new();
            year         = ccc_pkg::YEAR_RESET;
            month        = ccc_pkg::MONTH_MIN;
            day          = ccc_pkg::DAY_MIN;
            hour         = '0;
            minute       = '0;
            second       = '0;
            cd_hours     = '0;
            cd_minutes   = '0;
            cd_seconds   = '0;
            cd_running   = 1'b0;
            errors       = 0;
            results_seen = 0;
        endfunction

        static function int clamp(int v, int lo, int hi);
            if (v < lo)
            begin
                return lo;
            end
            if (v > hi)
            begin
                return hi;
            end
            return v;
        endfunction

        // Gregorian month length.
        static function int month_days(int m, int y);
            bit leap;
            leap = (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
            if (m == int'(ccc_pkg::MONTH_FEB))
            begin
                return leap ? 29 : 28;
            end
            if (m == int'(ccc_pkg::MONTH_APR) || m == int'(ccc_pkg::MONTH_JUN) ||
                m == int'(ccc_pkg::MONTH_SEP) || m == int'(ccc_pkg::MONTH_NOV))
            begin
                return 30;
            end
            return 31;
        endfunction

        // One second forward with carry through the whole date. A loaded day past
        // the month's length rolls to the first of the next month at midnight.
        function void advance_calendar();
            if (second < ccc_pkg::SEC_MAX)
            begin
                second++;
                return;
            end
            second = '0;
            if (minute < ccc_pkg::MIN_MAX)
            begin
                minute++;
                return;
            end
            minute = '0;
            if (hour < ccc_pkg::HOUR_MAX)
            begin
                hour++;
                return;
            end
            hour = '0;
            if (int'(day) < month_days(int'(month), int'(year)))
            begin
                day++;
                return;
            end
            day = ccc_pkg::DAY_MIN;
            if (month < ccc_pkg::MONTH_MAX)
            begin
                month++;
                return;
            end
            month = ccc_pkg::MONTH_MIN;
            year  = (year >= ccc_pkg::YEAR_MAX) ? '0 : year + 1'b1;
        endfunction

        // Applies one accepted item and queues the state that should come back for it.
        function void note_operation(ccc_pkg::ccc_user_t op_user, ccc_pkg::ccc_load_t ld);
            ccc_pkg::ccc_result_t r;
            logic                 done;
            done = 1'b0;
            case (op_user.opcode)
                ccc_pkg::OP_TICK:
                begin
                    if (!op_user.pause_calendar)
                    begin
                        advance_calendar();
                    end
                    if (cd_running && op_user.countdown_selected)
                    begin
                        // Already at zero: this tick stops it and flags done.
                        if (cd_hours == '0 && cd_minutes == '0 && cd_seconds == '0)
                        begin
                            cd_running = 1'b0;
                            done       = 1'b1;
                        end
                        else if (cd_seconds != '0)
                        begin
                            cd_seconds--;
                        end
                        else
                        begin
                            cd_seconds = ccc_pkg::SEC_MAX;
                            if (cd_minutes != '0)
                            begin
                                cd_minutes--;
                            end
                            else
                            begin
                                cd_minutes = ccc_pkg::MIN_MAX;
                                cd_hours--;
                            end
                        end
                    end
                end
                ccc_pkg::OP_LOAD_CAL:
                begin
                    year   = ccc_pkg::YEAR_W'(clamp(int'(ld.load_year), 0,
                                                    int'(ccc_pkg::YEAR_MAX)));
                    month  = ccc_pkg::MONTH_W'(clamp(int'(ld.load_month),
                                                     int'(ccc_pkg::MONTH_MIN),
                                                     int'(ccc_pkg::MONTH_MAX)));
                    day    = ccc_pkg::DAY_W'(clamp(int'(ld.load_day),
                                                   int'(ccc_pkg::DAY_MIN),
                                                   int'(ccc_pkg::DAYS_LONG)));
                    hour   = ccc_pkg::HOUR_W'(clamp(int'(ld.load_hour), 0,
                                                    int'(ccc_pkg::HOUR_MAX)));
                    minute = ccc_pkg::MIN_W'(clamp(int'(ld.load_minute), 0,
                                                   int'(ccc_pkg::MIN_MAX)));
                    second = ccc_pkg::SEC_W'(clamp(int'(ld.load_second), 0,
                                                   int'(ccc_pkg::SEC_MAX)));
                end
                ccc_pkg::OP_LOAD_CD:
                begin
                    cd_hours   = ccc_pkg::CD_HR_W'(clamp(int'(ld.load_cd_hours), 0,
                                                         int'(ccc_pkg::CD_HR_MAX)));
                    cd_minutes = ccc_pkg::MIN_W'(clamp(int'(ld.load_cd_minutes), 0,
                                                       int'(ccc_pkg::MIN_MAX)));
                    cd_seconds = ccc_pkg::SEC_W'(clamp(int'(ld.load_cd_seconds), 0,
                                                       int'(ccc_pkg::SEC_MAX)));
                    cd_running = 1'b1;
                end
                default:
                begin
                    cd_running = 1'b0;
                end
            endcase
            r.year       = year;
            r.month      = month;
            r.day        = day;
            r.hour       = hour;
            r.minute     = minute;
            r.second     = second;
            r.cd_hours   = cd_hours;
            r.cd_minutes = cd_minutes;
            r.cd_seconds = cd_seconds;
            r.cd_running = cd_running;
            r.cd_done    = done;
            expected_states.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task compare(string field, logic [63:0] got, logic [63:0] want);
            if (got !== want)
            begin
                report($sformatf("result %0d %s: got %0d, expected %0d",
                                 results_seen, field, got, want));
            end
        endtask

        // Checks one result item against the oldest expected state.
        task check_state(logic [ccc_pkg::TDATA_W-1:0] data);
            ccc_pkg::ccc_result_t got;
            ccc_pkg::ccc_result_t want;
            got = data[ccc_pkg::RESULT_W-1:0];
            results_seen++;
            if (expected_states.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing expected", results_seen));
                return;
            end
            want = expected_states.pop_front();
            compare("year", 64'(got.year), 64'(want.year));
            compare("month", 64'(got.month), 64'(want.month));
            compare("day", 64'(got.day), 64'(want.day));
            compare("hour", 64'(got.hour), 64'(want.hour));
            compare("minute", 64'(got.minute), 64'(want.minute));
            compare("second", 64'(got.second), 64'(want.second));
            compare("cd_hours", 64'(got.cd_hours), 64'(want.cd_hours));
            compare("cd_minutes", 64'(got.cd_minutes), 64'(want.cd_minutes));
            compare("cd_seconds", 64'(got.cd_seconds), 64'(want.cd_seconds));
            compare("cd_running", 64'(got.cd_running), 64'(want.cd_running));
            compare("cd_done", 64'(got.cd_done), 64'(want.cd_done));
            compare("padding", 64'(data[ccc_pkg::TDATA_W-1:ccc_pkg::RESULT_W]), '0);
        endtask
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [ccc_pkg::TDATA_W-1:0] s_tdata;
    logic [ccc_pkg::TUSER_W-1:0] s_tuser;
    logic                        m_tvalid;
    logic                        m_tready;
    logic [ccc_pkg::TDATA_W-1:0] m_tdata;

    calendar_tracker tracker = new();

    // Flags shared by sender and receiver; counters of the sender and the hang detector.
    bit hold_request = 1'b0;
    bit quiet_tail   = 1'b0;
    int items_sent   = 0;
    int idle_cycles  = 0;

    calendar_clock_with_countdown_top u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // All sampling happens at the rising edge, where every signal still shows the
    // value it held through the cycle that just ended, so the order in which this
    // block and the block's flops wake up does not matter.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_tvalid && m_tready)
        begin
            tracker.check_state(m_tdata);
        end
    end

    // Hang detector: counts cycles in which neither side moves an item.
    always @(posedge clk)
    begin
        if ((s_tvalid === 1'b1 && s_tready === 1'b1) ||
            (m_tvalid === 1'b1 && m_tready === 1'b1))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver. Each pass sets ready once and then waits on the clock before the next,
    // so ready never gets two updates in the same time step. Stalls come in short
    // random bursts, ready-high stretches between them, and once a long hold that
    // backs the block up while the sender keeps offering items.
    initial
    begin
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet_tail && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // Drops valid for a number of cycles; the next item raises it again in a later step.
    task automatic idle_input(int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Offers one item and holds it until the block takes it. Valid stays high into
    // the next item when no gap follows, so it is never lowered and raised in one step.
    task automatic send_op(ccc_pkg::ccc_op_t op, logic pause, logic cd_sel,
                           ccc_pkg::ccc_load_t ld);
        ccc_pkg::ccc_user_t op_user;
        op_user.opcode             = op;
        op_user.pause_calendar     = pause;
        op_user.countdown_selected = cd_sel;
        if (!quiet_tail && $urandom_range(0, 6) == 0)
        begin
            idle_input($urandom_range(1, 13));
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op_user;
        s_tdata  <= ccc_pkg::TDATA_W'(ld);
        do
        begin
            @(posedge clk);
        end
        while (s_tready !== 1'b1);
        tracker.note_operation(op_user, ld);
        items_sent++;
    endtask

    task automatic wait_for_results();
        while (tracker.expected_states.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Mostly an in-range value, now and then anything the field's width allows,
    // which exercises the saturation of out-of-range loads.
    function automatic int pick(int lo, int hi, int width);
        if ($urandom_range(0, 7) == 0)
        begin
            return int'($urandom_range(0, (1 << width) - 1));
        end
        return int'($urandom_range(lo, hi));
    endfunction

    function automatic ccc_pkg::ccc_load_t random_load();
        ccc_pkg::ccc_load_t ld;
        ld.load_year       = ccc_pkg::YEAR_W'(pick(0, int'(ccc_pkg::YEAR_MAX),
                                                   ccc_pkg::YEAR_W));
        ld.load_month      = ccc_pkg::MONTH_W'(pick(int'(ccc_pkg::MONTH_MIN),
                                                    int'(ccc_pkg::MONTH_MAX),
                                                    ccc_pkg::MONTH_W));
        ld.load_day        = ccc_pkg::DAY_W'(pick(int'(ccc_pkg::DAY_MIN),
                                                  int'(ccc_pkg::DAYS_LONG),
                                                  ccc_pkg::DAY_W));
        ld.load_hour       = ccc_pkg::HOUR_W'(pick(0, int'(ccc_pkg::HOUR_MAX),
                                                   ccc_pkg::HOUR_W));
        ld.load_minute     = ccc_pkg::MIN_W'(pick(0, int'(ccc_pkg::MIN_MAX),
                                                  ccc_pkg::MIN_W));
        ld.load_second     = ccc_pkg::SEC_W'(pick(0, int'(ccc_pkg::SEC_MAX),
                                                  ccc_pkg::SEC_W));
        ld.load_cd_hours   = ccc_pkg::CD_HR_W'(pick(0, int'(ccc_pkg::CD_HR_MAX),
                                                    ccc_pkg::CD_HR_W));
        ld.load_cd_minutes = ccc_pkg::MIN_W'(pick(0, int'(ccc_pkg::MIN_MAX),
                                                  ccc_pkg::MIN_W));
        ld.load_cd_seconds = ccc_pkg::SEC_W'(pick(0, int'(ccc_pkg::SEC_MAX),
                                                  ccc_pkg::SEC_W));
        return ld;
    endfunction

    function automatic ccc_pkg::ccc_load_t make_cal(int y, int mo, int d, int h, int mi,
                                                    int s);
        ccc_pkg::ccc_load_t ld;
        ld             = '0;
        ld.load_year   = ccc_pkg::YEAR_W'(y);
        ld.load_month  = ccc_pkg::MONTH_W'(mo);
        ld.load_day    = ccc_pkg::DAY_W'(d);
        ld.load_hour   = ccc_pkg::HOUR_W'(h);
        ld.load_minute = ccc_pkg::MIN_W'(mi);
        ld.load_second = ccc_pkg::SEC_W'(s);
        return ld;
    endfunction

    function automatic ccc_pkg::ccc_load_t make_cd(int h, int mi, int s);
        ccc_pkg::ccc_load_t ld;
        ld                 = '0;
        ld.load_cd_hours   = ccc_pkg::CD_HR_W'(h);
        ld.load_cd_minutes = ccc_pkg::MIN_W'(mi);
        ld.load_cd_seconds = ccc_pkg::SEC_W'(s);
        return ld;
    endfunction

    // A calendar load, usually a few seconds short of a rollover (often at or past the end
    // of the month, often in a year that matters for leap days), then some ticks.
    task automatic calendar_run();
        int                 leap_years[12] = '{0, 1, 4, 100, 400, 1900, 2000, 2023, 2024,
                                               2100, 9996, 9999};
        ccc_pkg::ccc_load_t ld;
        int                 ticks;
        ld = random_load();
        if ($urandom_range(0, 3) != 0)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                ld.load_year = ccc_pkg::YEAR_W'(leap_years[$urandom_range(0, 11)]);
            end
            ld.load_month  = ($urandom_range(0, 3) == 0) ? ccc_pkg::MONTH_FEB :
                             ccc_pkg::MONTH_W'($urandom_range(1, 12));
            ld.load_day    = ccc_pkg::DAY_W'($urandom_range(26, 31));
            ld.load_hour   = ccc_pkg::HOUR_MAX;
            ld.load_minute = ccc_pkg::MIN_MAX;
            ld.load_second = ccc_pkg::SEC_W'($urandom_range(52, 59));
        end
        send_op(ccc_pkg::OP_LOAD_CAL, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                ld);
        ticks = int'($urandom_range(1, 12));
        repeat (ticks)
        begin
            send_op(ccc_pkg::OP_TICK, $urandom_range(0, 5) == 0, 1'($urandom_range(0, 1)),
                    random_load());
        end
    endtask

    // A countdown load, usually short, then ticks mostly in countdown mode, so that borrows,
    // the stop at zero and the done flag come up often. Now and then it is stopped.
    task automatic countdown_run();
        ccc_pkg::ccc_load_t ld;
        int                 ticks;
        ld = random_load();
        if ($urandom_range(0, 3) != 0)
        begin
            ld.load_cd_hours   = ccc_pkg::CD_HR_W'($urandom_range(0, 1));
            ld.load_cd_minutes = ccc_pkg::MIN_W'($urandom_range(0, 1));
            ld.load_cd_seconds = ccc_pkg::SEC_W'($urandom_range(0, 4));
        end
        send_op(ccc_pkg::OP_LOAD_CD, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                ld);
        ticks = int'($urandom_range(1, 12));
        repeat (ticks)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                send_op(ccc_pkg::OP_STOP_CD, 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), random_load());
            end
            else
            begin
                send_op(ccc_pkg::OP_TICK, $urandom_range(0, 3) == 0,
                        $urandom_range(0, 5) != 0, random_load());
            end
        end
    endtask

    initial
    begin
        bit hold_done;
        bit drain_done;
        int pick_run;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. First second after reset, then loads with every field at
        // its top and at zero, which must saturate into range.
        send_op(ccc_pkg::OP_TICK, 1'b0, 1'b0, '0);
        send_op(ccc_pkg::OP_LOAD_CAL, 1'b1, 1'b1, '1);
        // 9999-12-31 23:59:59 plus one second wraps the year to zero.
        send_op(ccc_pkg::OP_TICK, 1'b0, 1'b1, '0);
        send_op(ccc_pkg::OP_LOAD_CAL, 1'b0, 1'b0, '0);
        // Leap day in an ordinary leap year, then a paused tick that must hold.
        send_op(ccc_pkg::OP_LOAD_CAL, 1'b0, 1'b0, make_cal(2024, 2, 28, 23, 59, 59));
        send_op(ccc_pkg::OP_TICK, 1'b0, 1'b0, '0);
        send_op(ccc_pkg::OP_TICK, 1'b1, 1'b0, '0);
        // Century that is not a leap year, and one that is.
        send_op(ccc_pkg::OP_LOAD_CAL, 1'b0, 1'b0, make_cal(2100, 2, 28, 23, 59, 59));
        send_op(ccc_pkg::OP_TICK, 1'b0, 1'b0, '0);
        send_op(ccc_pkg::OP_LOAD_CAL, 1'b0, 1'b0, make_cal(2000, 2, 29, 23, 59, 59));
        send_op(ccc_pkg::OP_TICK, 1'b0, 1'b0, '0);
        // A day loaded past the end of its month is kept until midnight.
        send_op(ccc_pkg::OP_LOAD_CAL, 1'b0, 1'b0, make_cal(2023, 2, 31, 23, 59, 59));
        send_op(ccc_pkg::OP_TICK, 1'b0, 1'b0, '0);
        send_op(ccc_pkg::OP_LOAD_CAL, 1'b0, 1'b0, make_cal(2023, 4, 30, 23, 59, 59));
        send_op(ccc_pkg::OP_TICK, 1'b0, 1'b0, '0);
        // Stopping a countdown that is not running changes nothing.
        send_op(ccc_pkg::OP_STOP_CD, 1'b1, 1'b1, '1);
        // An all-zero countdown starts, and its first counting tick stops it with done.
        send_op(ccc_pkg::OP_LOAD_CD, 1'b1, 1'b0, '0);
        send_op(ccc_pkg::OP_TICK, 1'b0, 1'b1, '0);
        send_op(ccc_pkg::OP_TICK, 1'b0, 1'b1, '0);
        // Countdown load saturates at 99:59:59; a tick outside countdown mode leaves it.
        send_op(ccc_pkg::OP_LOAD_CD, 1'b0, 1'b1, '1);
        send_op(ccc_pkg::OP_TICK, 1'b0, 1'b1, '0);
        send_op(ccc_pkg::OP_TICK, 1'b1, 1'b0, '0);
        // Borrow from the hours and from the minutes.
        send_op(ccc_pkg::OP_LOAD_CD, 1'b0, 1'b0, make_cd(1, 0, 0));
        send_op(ccc_pkg::OP_TICK, 1'b0, 1'b1, '0);
        send_op(ccc_pkg::OP_LOAD_CD, 1'b0, 1'b0, make_cd(0, 1, 0));
        send_op(ccc_pkg::OP_TICK, 1'b0, 1'b1, '0);
        send_op(ccc_pkg::OP_STOP_CD, 1'b0, 1'b0, '0);
        send_op(ccc_pkg::OP_TICK, 1'b0, 1'b1, '0);

        // Random part: mostly well-formed runs around rollovers and countdown ends,
        // the rest single items of any kind with any field values.
        while (items_sent < ITEM_COUNT)
        begin
            if (!hold_done && items_sent >= ITEM_COUNT / 4)
            begin
                // The receiver holds off while items keep coming, until the block
                // can take no more and drops its input ready.
                hold_done    = 1'b1;
                hold_request = 1'b1;
            end
            if (!drain_done && items_sent >= ITEM_COUNT / 2)
            begin
                drain_done = 1'b1;
                idle_input(1);
                wait_for_results();
            end
            if (items_sent >= ITEM_COUNT - TAIL_ITEMS)
            begin
                quiet_tail = 1'b1;
            end
            pick_run = int'($urandom_range(0, 9));
            if (pick_run < 4)
            begin
                calendar_run();
            end
            else if (pick_run < 7)
            begin
                countdown_run();
            end
            else
            begin
                send_op(ccc_pkg::ccc_op_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), random_load());
            end
        end

        s_tvalid <= 1'b0;
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/ccc_pkg.sv
src/calendar_clock_with_countdown_top.sv
tb/sv/tb.sv
